[rtl/nlrb_pkg.sv]
// Package for the newline line ring buffer.
// Holds default sizes, the newline code, operation codes and the sequencer state type.
// No dependencies.
package nlrb_pkg;

   localparam int SLOTS_DEFAULT    = 4;
   localparam int LINE_LEN_DEFAULT = 64;

   localparam logic [7:0] NEWLINE_BYTE = 8'd10;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_POP  = 2'b10
   } state_type;

endpackage

[rtl/newline_line_ring_buffer.sv]
// Newline line ring buffer: a ring of line slots held in one byte-wide synchronous memory.
// Depends on nlrb_pkg for default sizes, codes and the state type.
// Timing: push completes at accept. A pop gives a registered empty answer when nothing is ready
// or the length is zero, or after reading the first byte when it is zero; else bytes follow.
// Throughput: one push per cycle while not busy; a pop holds busy while it reads each byte, plus
// one byte of lookahead for the last mark, and takes no new request. The receiver cannot stall.
// Reset (synchronous): clears slot pointers, fill position, lengths and ready marks; the byte
// memory is not cleared, as no byte at or beyond a slot's stored length is ever emitted.
module newline_line_ring_buffer #(
   parameter int SLOTS    = nlrb_pkg::SLOTS_DEFAULT,
   parameter int LINE_LEN = nlrb_pkg::LINE_LEN_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_operation,
   input  logic [7:0] req_data_byte,
   output logic       rsp_strobe,
   output logic       rsp_line_available,
   output logic       rsp_byte_valid,
   output logic [7:0] rsp_line_byte,
   output logic       rsp_last
);

   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PW    = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
   localparam int LW    = $clog2(LINE_LEN + 1);
   localparam int AW    = SW + PW;
   localparam int DEPTH = SLOTS << PW;

   logic [7:0]     mem [DEPTH];
   logic [7:0]     rd_data_ff;
   logic [AW-1:0]  rd_addr;
   logic [AW-1:0]  wr_addr;

   logic [LW-1:0]  line_len_ff [SLOTS];
   logic           ready_ff [SLOTS];
   logic [SW-1:0]  wslot_ff;
   logic [SW-1:0]  rslot_ff;
   logic [LW-1:0]  fill_ff;

   nlrb_pkg::state_type state_ff;
   logic [SW-1:0]  pop_slot_ff;
   logic [LW-1:0]  pop_len_ff;
   logic [LW-1:0]  ridx_ff;
   logic           hold_valid_ff;
   logic [7:0]     hold_ff;

   logic           rsp_strobe_ff;
   logic           rsp_avail_ff;
   logic           rsp_valid_ff;
   logic [7:0]     rsp_byte_ff;
   logic           rsp_last_ff;

   logic           accept;
   logic           push_acc;
   logic           pop_acc;
   logic           store_en;
   logic           is_newline;
   logic [LW-1:0]  fill_in;
   logic [SW-1:0]  wslot_in;
   logic [SW-1:0]  rslot_in;
   logic [LW-1:0]  ridx_in;
   logic           pop_end;
   logic           rsp_strobe_in;

   assign busy       = (state_ff != nlrb_pkg::ST_IDLE);
   assign accept     = start && !busy;
   assign push_acc   = accept && (req_operation == nlrb_pkg::OP_PUSH);
   assign pop_acc    = accept && (req_operation == nlrb_pkg::OP_POP);
   assign store_en   = push_acc && (fill_ff < LW'(LINE_LEN));
   assign is_newline = (req_data_byte == nlrb_pkg::NEWLINE_BYTE);
   assign fill_in    = fill_ff + LW'(1);
   assign wslot_in   = (wslot_ff == SW'(SLOTS - 1)) ? '0 : wslot_ff + SW'(1);
   assign rslot_in   = (rslot_ff == SW'(SLOTS - 1)) ? '0 : rslot_ff + SW'(1);
   assign ridx_in    = ridx_ff + LW'(1);
   assign pop_end    = (ridx_ff >= pop_len_ff) || (rd_data_ff == 8'd0);

   assign rsp_strobe_in = (pop_acc && (!ready_ff[rslot_ff] || (line_len_ff[rslot_ff] == '0)))
                          || ((state_ff == nlrb_pkg::ST_POP) && (hold_valid_ff || pop_end));

   assign wr_addr = {wslot_ff, fill_ff[PW-1:0]};
   assign rd_addr = (state_ff == nlrb_pkg::ST_POP) ? {pop_slot_ff, ridx_in[PW-1:0]}
                                                   : {rslot_ff, PW'(0)};

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_line_available = rsp_avail_ff;
   assign rsp_byte_valid     = rsp_valid_ff;
   assign rsp_line_byte      = rsp_byte_ff;
   assign rsp_last           = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (store_en) begin
         mem[wr_addr] <= req_data_byte;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            line_len_ff[i] <= '0;
            ready_ff[i]    <= 1'b0;
         end
         wslot_ff      <= '0;
         rslot_ff      <= '0;
         fill_ff       <= '0;
         state_ff      <= nlrb_pkg::ST_IDLE;
         hold_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;

         // push: store if room, close the line on newline
         if (store_en) begin
            line_len_ff[wslot_ff] <= fill_in;
         end
         if (push_acc && is_newline) begin
            ready_ff[wslot_ff]    <= 1'b1;
            line_len_ff[wslot_in] <= '0;
            wslot_ff              <= wslot_in;
            fill_ff               <= '0;
         end else if (store_en) begin
            fill_ff <= fill_in;
         end

         // pop accept: answer at once when nothing to emit, else start the read sequence
         if (pop_acc) begin
            rsp_byte_ff  <= 8'd0;
            rsp_valid_ff <= 1'b0;
            rsp_last_ff  <= 1'b1;
            if (!ready_ff[rslot_ff]) begin
               rsp_avail_ff <= 1'b0;
            end else begin
               ready_ff[rslot_ff] <= 1'b0;
               rslot_ff           <= rslot_in;
               if (line_len_ff[rslot_ff] == '0) begin
                  rsp_avail_ff <= 1'b1;
               end else begin
                  state_ff      <= nlrb_pkg::ST_POP;
                  pop_slot_ff   <= rslot_ff;
                  pop_len_ff    <= line_len_ff[rslot_ff];
                  ridx_ff       <= '0;
                  hold_valid_ff <= 1'b0;
               end
            end
         end

         // emit the held byte once the next one tells whether it is the last; end empty on a zero first byte
         if (state_ff == nlrb_pkg::ST_POP) begin
            ridx_ff <= ridx_in;
            hold_ff <= rd_data_ff;
            if (!hold_valid_ff) begin
               hold_valid_ff <= 1'b1;
               if (pop_end) begin
                  rsp_avail_ff <= 1'b1;
                  rsp_valid_ff <= 1'b0;
                  rsp_byte_ff  <= 8'd0;
                  rsp_last_ff  <= 1'b1;
                  state_ff     <= nlrb_pkg::ST_IDLE;
               end
            end else begin
               rsp_avail_ff <= 1'b1;
               rsp_valid_ff <= 1'b1;
               rsp_byte_ff  <= hold_ff;
               rsp_last_ff  <= pop_end;
               if (pop_end) begin
                  state_ff <= nlrb_pkg::ST_IDLE;
               end
            end
         end
      end
   end

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_valid_ff) |-> (rsp_last_ff && (rsp_byte_ff == 8'd0)))
      else $error("result without a byte is not the final one");

   a_valid_needs_line: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_valid_ff) |-> rsp_avail_ff)
      else $error("byte emitted without an available line");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nlrb_pkg::ST_POP) |-> (ridx_ff <= pop_len_ff))
      else $error("pop index ran past the stored length");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LW'(LINE_LEN))
      else $error("fill position beyond line length");

   a_push_no_busy: assert property (@(posedge clock) disable iff (reset)
      push_acc |=> (!busy && !rsp_strobe_ff))
      else $error("push caused busy or a result");

endmodule
